// ===== sv/fwc_pkg.sv =====
// ============================================================================
// fwc_pkg
// Shared types, codes and constants of the fade and wipe transition
// controller.
// ============================================================================
`default_nettype none

package fwc_pkg;

    // Step and alpha limits.
    localparam logic [7:0] STEP_MIN   = 8'd1;
    localparam logic [7:0] STEP_MAX   = 8'd255;
    localparam logic [7:0] ALPHA_MIN  = 8'd0;
    localparam logic [7:0] ALPHA_MAX  = 8'd255;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    // Stream widths.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 112;
    localparam int CFG_DATA_W = 12;

    // Depth of the queue between the front and back parts (power of two).
    localparam int QUEUE_DEPTH = 2;

    // Input command codes.
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_FADE_IN  = 2'd1,
        OP_FADE_OUT = 2'd2,
        OP_LOAD     = 2'd3
    } op_t;

    // Fade phase codes.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_IN   = 2'd1,
        PH_OUT  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    // Draw descriptor kinds.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_BLEND = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_PART  = 2'd3
    } kind_t;

    // Direction of a partial rectangle.
    typedef enum logic [2:0] {
        DIR_LEFT     = 3'd0,
        DIR_RIGHT    = 3'd1,
        DIR_TOP      = 3'd2,
        DIR_BOTTOM   = 3'd3,
        DIR_CENTER_H = 3'd4,
        DIR_CENTER_V = 3'd5
    } dir_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_WIPE_MODE     = 3'd0,
        REG_FPS           = 3'd1,
        REG_TARGET_X      = 3'd2,
        REG_TARGET_Y      = 3'd3,
        REG_TARGET_WIDTH  = 3'd4,
        REG_TARGET_HEIGHT = 3'd5,
        REG_SOURCE_WIDTH  = 3'd6,
        REG_SOURCE_HEIGHT = 3'd7
    } cfg_idx_t;

    // Wipe mode codes.
    localparam logic [3:0] WIPE_BLEND         = 4'd0;
    localparam logic [3:0] WIPE_FROM_LEFT     = 4'd1;
    localparam logic [3:0] WIPE_FROM_RIGHT    = 4'd2;
    localparam logic [3:0] WIPE_FROM_TOP      = 4'd3;
    localparam logic [3:0] WIPE_FROM_BOTTOM   = 4'd4;
    localparam logic [3:0] WIPE_FROM_SIDES    = 4'd5;
    localparam logic [3:0] WIPE_CENTER_SIDES  = 4'd6;
    localparam logic [3:0] WIPE_FROM_TOP_BOT  = 4'd7;
    localparam logic [3:0] WIPE_CENTER_TOP_BOT = 4'd8;

    // Configuration register set.
    typedef struct packed {
        logic [3:0]         wipe_mode;
        logic [7:0]         frames_per_second;
        logic signed [11:0] target_x;
        logic signed [11:0] target_y;
        logic [11:0]        target_width;
        logic [11:0]        target_height;
        logic [11:0]        source_width;
        logic [11:0]        source_height;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        wipe_mode:         4'd0,
        frames_per_second: 8'd60,
        target_x:          12'sd0,
        target_y:          12'sd0,
        target_width:      12'd640,
        target_height:     12'd480,
        source_width:      12'd640,
        source_height:     12'd480
    };

    // Classified item passed from the front part to the back part.
    typedef struct packed {
        logic [7:0] alpha;
        phase_t     phase;
        kind_t      kind;
        dir_t       dir;
        logic [7:0] amount;
        logic       split;
    } job_t;

    // Draw descriptor as packed on the output data bus, lowest field last.
    typedef struct packed {
        logic [11:0]        src_h;
        logic [11:0]        src_w;
        logic [11:0]        src_y;
        logic [11:0]        src_x;
        logic [11:0]        dest_h;
        logic [11:0]        dest_w;
        logic signed [12:0] dest_y;
        logic signed [12:0] dest_x;
        phase_t             fade_phase;
        logic [7:0]         alpha_now;
    } desc_t;

    localparam int OUT_PAD_W = OUT_DATA_W - $bits(desc_t);

endpackage

`default_nettype wire

// ===== sv/fwc_cfg.sv =====
// ============================================================================
// fwc_cfg
// Configuration register file, written through a plain write port.
// ============================================================================
`default_nettype none

module fwc_cfg
    import fwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and update the addressed field.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_WIPE_MODE:     cfg_next.wipe_mode         = cfg_data[3:0];
                REG_FPS:           cfg_next.frames_per_second = cfg_data[7:0];
                REG_TARGET_X:      cfg_next.target_x          = $signed(cfg_data);
                REG_TARGET_Y:      cfg_next.target_y          = $signed(cfg_data);
                REG_TARGET_WIDTH:  cfg_next.target_width      = cfg_data;
                REG_TARGET_HEIGHT: cfg_next.target_height     = cfg_data;
                REG_SOURCE_WIDTH:  cfg_next.source_width      = cfg_data;
                REG_SOURCE_HEIGHT: cfg_next.source_height     = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/fwc_front.sv =====
// ============================================================================
// fwc_front
// Front part: accepts commands, keeps the fade state, derives the step per
// frame with a two-bit-per-cycle divider and classifies each item.
// ============================================================================
`default_nettype none

module fwc_front
    import fwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_DATA_W-1:0] in_data,
    input  logic [1:0]           in_user,
    input  logic                 q_full,
    output logic                 push,
    output job_t                 push_job
);

    localparam int DIV_CYCLES = 4;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Architectural fade state.
    logic [7:0] alpha_reg, alpha_next;
    logic [7:0] step_reg, step_next;
    phase_t     phase_reg, phase_next;
    logic       pend_in_reg, pend_in_next;
    logic       pend_out_reg, pend_out_next;

    // Divider control and datapath.
    logic                 div_busy_reg, div_busy_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [15:0]          div_rem_reg, div_rem_next;
    logic [7:0]           div_num_reg, div_num_next;
    logic [7:0]           div_quo_reg, div_quo_next;
    logic [15:0]          div_den_reg, div_den_next;

    logic              accept;
    op_t               op;
    logic [15:0]       dur;
    logic [7:0]        load_val;
    logic [15:0]       numer;
    logic              step_sat;
    logic signed [9:0] diff;
    logic signed [9:0] sum;
    logic [7:0]        alpha_dec;
    logic [7:0]        alpha_inc;
    logic [16:0]       r1, r1s, r2, r2s;
    logic              b1, b2;
    logic [7:0]        quo_upd;

    function automatic logic [7:0] clamp_alpha(input logic signed [9:0] v);
        logic [7:0] res;
        if (v < $signed({2'b00, ALPHA_MIN}))
            res = ALPHA_MIN;
        else if (v > $signed({2'b00, ALPHA_MAX}))
            res = ALPHA_MAX;
        else
            res = v[7:0];
        return res;
    endfunction

    function automatic logic [7:0] clamp_step(input logic [7:0] q);
        logic [7:0] res;
        if (q < STEP_MIN)
            res = STEP_MIN;
        else if (q > STEP_MAX)
            res = STEP_MAX;
        else
            res = q;
        return res;
    endfunction

    // Input handshake: stall while the queue is full or a step is pending.
    assign in_ready = !q_full && !div_busy_reg;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    assign op       = op_t'(in_user);
    assign dur      = in_data[15:0];
    assign load_val = in_data[23:16];

    // Dividend is 255 * frames_per_second; a quotient of 256 or more, or a
    // zero duration, saturates the step straight away.
    assign numer    = {cfg.frames_per_second, 8'd0} - {8'd0, cfg.frames_per_second};
    assign step_sat = (dur == 16'd0) || ({8'd0, numer[15:8]} >= dur);

    // Alpha stepping for a frame tick.
    assign diff      = $signed({2'b00, alpha_reg}) - $signed({2'b00, step_reg});
    assign sum       = $signed({2'b00, alpha_reg}) + $signed({2'b00, step_reg});
    assign alpha_dec = clamp_alpha(diff);
    assign alpha_inc = clamp_alpha(sum);

    // Two restoring division steps per cycle.
    always_comb
    begin
        r1      = {1'b0, div_rem_reg[15:0]} << 1;
        r1[0]   = div_num_reg[7];
        b1      = (r1 >= {1'b0, div_den_reg});
        r1s     = b1 ? (r1 - {1'b0, div_den_reg}) : r1;
        r2      = {r1s[15:0], div_num_reg[6]};
        b2      = (r2 >= {1'b0, div_den_reg});
        r2s     = b2 ? (r2 - {1'b0, div_den_reg}) : r2;
        quo_upd = {div_quo_reg[5:0], b1, b2};
    end

    // State update for the accepted command or the running division.
    always_comb
    begin
        alpha_next    = alpha_reg;
        step_next     = step_reg;
        phase_next    = phase_reg;
        pend_in_next  = pend_in_reg;
        pend_out_next = pend_out_reg;
        div_busy_next = div_busy_reg;
        div_cnt_next  = div_cnt_reg;
        div_rem_next  = div_rem_reg;
        div_num_next  = div_num_reg;
        div_quo_next  = div_quo_reg;
        div_den_next  = div_den_reg;

        if (div_busy_reg)
        begin
            div_rem_next = r2s[15:0];
            div_num_next = {div_num_reg[5:0], 2'b00};
            div_quo_next = quo_upd;
            div_cnt_next = div_cnt_reg + 1'b1;
            if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                div_busy_next = 1'b0;
                step_next     = clamp_step(quo_upd);
            end
        end
        else if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (pend_in_reg)
                            begin
                                phase_next   = PH_IN;
                                pend_in_next = 1'b0;
                            end
                            else if (pend_out_reg)
                            begin
                                phase_next    = PH_OUT;
                                pend_out_next = 1'b0;
                            end
                        end
                        PH_IN:
                        begin
                            alpha_next = alpha_dec;
                            if (alpha_dec == ALPHA_MIN)
                                phase_next = PH_DONE;
                        end
                        PH_OUT:
                        begin
                            alpha_next = alpha_inc;
                            if (alpha_inc == ALPHA_MAX)
                                phase_next = PH_DONE;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                OP_FADE_IN, OP_FADE_OUT:
                begin
                    phase_next = PH_IDLE;
                    if (op == OP_FADE_IN)
                    begin
                        alpha_next   = ALPHA_MAX;
                        pend_in_next = 1'b1;
                    end
                    else
                    begin
                        alpha_next    = ALPHA_MIN;
                        pend_out_next = 1'b1;
                    end
                    if (step_sat)
                    begin
                        step_next = STEP_MAX;
                    end
                    else
                    begin
                        div_busy_next = 1'b1;
                        div_cnt_next  = '0;
                        div_rem_next  = {8'd0, numer[15:8]};
                        div_num_next  = numer[7:0];
                        div_quo_next  = 8'd0;
                        div_den_next  = dur;
                    end
                end
                default:
                begin
                    alpha_next = load_val;
                end
            endcase
        end
    end

    // Classify the item by the alpha it leaves and the wipe mode.
    always_comb
    begin
        push_job.alpha  = alpha_next;
        push_job.phase  = phase_next;
        push_job.kind   = KIND_NONE;
        push_job.dir    = DIR_LEFT;
        push_job.amount = alpha_next;
        push_job.split  = 1'b0;

        if (alpha_next == ALPHA_MIN)
        begin
            push_job.kind = KIND_NONE;
        end
        else if (alpha_next >= ALPHA_MAX)
        begin
            push_job.kind = KIND_FULL;
        end
        else
        begin
            case (cfg.wipe_mode)
                WIPE_BLEND:
                begin
                    push_job.kind = KIND_BLEND;
                end
                WIPE_FROM_LEFT:
                begin
                    push_job.kind = KIND_PART;
                    push_job.dir  = DIR_RIGHT;
                end
                WIPE_FROM_RIGHT:
                begin
                    push_job.kind = KIND_PART;
                    push_job.dir  = DIR_LEFT;
                end
                WIPE_FROM_TOP:
                begin
                    push_job.kind = KIND_PART;
                    push_job.dir  = DIR_BOTTOM;
                end
                WIPE_FROM_BOTTOM:
                begin
                    push_job.kind = KIND_PART;
                    push_job.dir  = DIR_TOP;
                end
                WIPE_FROM_SIDES:
                begin
                    push_job.kind = KIND_PART;
                    push_job.dir  = DIR_CENTER_H;
                end
                WIPE_CENTER_SIDES:
                begin
                    push_job.kind   = KIND_PART;
                    push_job.dir    = DIR_LEFT;
                    push_job.amount = {1'b0, alpha_next[7:1]};
                    push_job.split  = 1'b1;
                end
                WIPE_FROM_TOP_BOT:
                begin
                    push_job.kind = KIND_PART;
                    push_job.dir  = DIR_CENTER_V;
                end
                WIPE_CENTER_TOP_BOT:
                begin
                    push_job.kind   = KIND_PART;
                    push_job.dir    = DIR_TOP;
                    push_job.amount = {1'b0, alpha_next[7:1]};
                    push_job.split  = 1'b1;
                end
                default:
                begin
                    push_job.kind = KIND_NONE;
                end
            endcase
        end
    end

    // Control and fade state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= ALPHA_MIN;
            step_reg     <= 8'd0;
            phase_reg    <= PH_IDLE;
            pend_in_reg  <= 1'b0;
            pend_out_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            alpha_reg    <= alpha_next;
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            pend_in_reg  <= pend_in_next;
            pend_out_reg <= pend_out_next;
            div_busy_reg <= div_busy_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    // Divider datapath.
    always_ff @(posedge clk)
    begin
        div_rem_reg <= div_rem_next;
        div_num_reg <= div_num_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
    end

endmodule

`default_nettype wire

// ===== sv/fwc_queue.sv =====
// ============================================================================
// fwc_queue
// Short first-in first-out queue of classified items between the front and
// back parts.
// ============================================================================
`default_nettype none

module fwc_queue
    import fwc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = PTR_W'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = PTR_W'(rd_ptr_reg + 1'b1);
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== sv/fwc_back.sv =====
// ============================================================================
// fwc_back
// Back part: turns each classified item into one or two draw descriptors,
// scaling sizes by alpha (halved for split wipes) over 255 and holds them
// in an output register.
// ============================================================================
`default_nettype none

module fwc_back
    import fwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  q_empty,
    input  job_t                  q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [1:0]            out_user,
    output logic                  out_last
);

    localparam logic signed [13:0] POS_MAX = 14'sd4095;
    localparam logic signed [13:0] POS_MIN = -14'sd4096;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_EST,
        B_FIX,
        B_EMIT
    } bstate_t;

    bstate_t     state_reg, state_next;
    job_t        job_reg, job_next;
    logic [19:0] prod_d_reg, prod_d_next;
    logic [19:0] prod_s_reg, prod_s_next;
    logic [11:0] est_d_reg, est_d_next;
    logic [11:0] est_s_reg, est_s_next;
    logic [11:0] part_d_reg, part_d_next;
    logic [11:0] part_s_reg, part_s_next;
    logic        out_valid_reg, out_valid_next;
    desc_t       out_desc_reg, out_desc_next;
    kind_t       out_kind_reg, out_kind_next;
    logic        out_last_reg, out_last_next;

    logic        horiz;
    logic [11:0] dim_d;
    logic [11:0] dim_s;
    logic        out_free;
    desc_t       desc;
    logic [11:0] off_x, off_y, src_ox, src_oy;
    logic signed [13:0] tx_ext, ty_ext;

    // Quotient estimate x*257/65536 never exceeds x/255 and is at most one
    // below it.
    function automatic logic [11:0] est_div(input logic [19:0] x);
        logic [27:0] t;
        t = {8'd0, x} + {x, 8'd0};
        return t[27:16];
    endfunction

    // One compare and increment corrects the estimate.
    function automatic logic [11:0] fix_div(input logic [19:0] x,
                                            input logic [11:0] q0);
        logic [19:0] back_prod;
        logic [19:0] rem;
        back_prod = {q0, 8'd0} - {8'd0, q0};
        rem       = x - back_prod;
        return (rem >= {12'd0, FULL_SCALE}) ? (q0 + 12'd1) : q0;
    endfunction

    function automatic logic signed [12:0] sat_pos(input logic signed [13:0] v);
        logic signed [12:0] res;
        if (v > POS_MAX)
            res = POS_MAX[12:0];
        else if (v < POS_MIN)
            res = POS_MIN[12:0];
        else
            res = v[12:0];
        return res;
    endfunction

    assign horiz = (job_reg.dir == DIR_LEFT) || (job_reg.dir == DIR_RIGHT) ||
                   (job_reg.dir == DIR_CENTER_H);
    assign dim_d = horiz ? cfg.target_width : cfg.target_height;
    assign dim_s = horiz ? cfg.source_width : cfg.source_height;

    assign tx_ext = {{2{cfg.target_x[11]}}, cfg.target_x};
    assign ty_ext = {{2{cfg.target_y[11]}}, cfg.target_y};

    assign out_free = !out_valid_reg || out_ready;

    // Offsets of partial rectangles inside the target and source.
    always_comb
    begin
        off_x  = 12'd0;
        off_y  = 12'd0;
        src_ox = 12'd0;
        src_oy = 12'd0;
        case (job_reg.dir)
            DIR_RIGHT:
            begin
                off_x  = cfg.target_width - part_d_reg;
                src_ox = cfg.source_width - part_s_reg;
            end
            DIR_BOTTOM:
            begin
                off_y  = cfg.target_height - part_d_reg;
                src_oy = cfg.source_height - part_s_reg;
            end
            DIR_CENTER_H:
            begin
                off_x  = {1'b0, cfg.target_width[11:1]} - {1'b0, part_d_reg[11:1]};
                src_ox = {1'b0, cfg.source_width[11:1]} - {1'b0, part_s_reg[11:1]};
            end
            DIR_CENTER_V:
            begin
                off_y  = {1'b0, cfg.target_height[11:1]} - {1'b0, part_d_reg[11:1]};
                src_oy = {1'b0, cfg.source_height[11:1]} - {1'b0, part_s_reg[11:1]};
            end
            default:
            begin
                off_x = 12'd0;
            end
        endcase
    end

    // Descriptor for the current item and direction.
    always_comb
    begin
        desc            = '0;
        desc.alpha_now  = job_reg.alpha;
        desc.fade_phase = job_reg.phase;
        case (job_reg.kind)
            KIND_BLEND, KIND_FULL:
            begin
                desc.dest_x = tx_ext[12:0];
                desc.dest_y = ty_ext[12:0];
                desc.dest_w = cfg.target_width;
                desc.dest_h = cfg.target_height;
                desc.src_w  = cfg.source_width;
                desc.src_h  = cfg.source_height;
            end
            KIND_PART:
            begin
                desc.dest_x = sat_pos(tx_ext + $signed({2'b00, off_x}));
                desc.dest_y = sat_pos(ty_ext + $signed({2'b00, off_y}));
                desc.dest_w = horiz ? part_d_reg : cfg.target_width;
                desc.dest_h = horiz ? cfg.target_height : part_d_reg;
                desc.src_x  = src_ox;
                desc.src_y  = src_oy;
                desc.src_w  = horiz ? part_s_reg : cfg.source_width;
                desc.src_h  = horiz ? cfg.source_height : part_s_reg;
            end
            default:
            begin
                desc.dest_w = 12'd0;
            end
        endcase
    end

    // Sequencer: fetch; for a partial item scale, estimate and correct; then
    // hand descriptors to the output register.
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        prod_d_next    = prod_d_reg;
        prod_s_next    = prod_s_reg;
        est_d_next     = est_d_reg;
        est_s_next     = est_s_reg;
        part_d_next    = part_d_reg;
        part_s_next    = part_s_reg;
        out_valid_next = out_valid_reg;
        out_desc_next  = out_desc_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_data;
                    state_next = (q_data.kind == KIND_PART) ? B_MUL : B_EMIT;
                end
            end
            B_MUL:
            begin
                prod_d_next = {8'd0, dim_d} * {12'd0, job_reg.amount};
                prod_s_next = {8'd0, dim_s} * {12'd0, job_reg.amount};
                state_next  = B_EST;
            end
            B_EST:
            begin
                est_d_next = est_div(prod_d_reg);
                est_s_next = est_div(prod_s_reg);
                state_next = B_FIX;
            end
            B_FIX:
            begin
                part_d_next = fix_div(prod_d_reg, est_d_reg);
                part_s_next = fix_div(prod_s_reg, est_s_reg);
                state_next  = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_desc_next  = desc;
                    out_kind_next  = job_reg.kind;
                    out_last_next  = !job_reg.split;
                    if (job_reg.split)
                    begin
                        // Second half of a split wipe uses the same sizes.
                        job_next.split = 1'b0;
                        job_next.dir   = dir_t'(job_reg.dir + 3'd1);
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        prod_d_reg   <= prod_d_next;
        prod_s_reg   <= prod_s_next;
        est_d_reg    <= est_d_next;
        est_s_reg    <= est_s_next;
        part_d_reg   <= part_d_next;
        part_s_reg   <= part_s_next;
        out_desc_reg <= out_desc_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{OUT_PAD_W{1'b0}}, out_desc_reg};
    assign out_user  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/fade_wipe_controller.sv =====
// A plain descriptor (nothing, blend or full copy) passes the queue, the back part's
// item register and the output register; a partial wipe one also passes the product,
// estimate and corrected-size registers. The back part takes a new item only after
// emitting the last; the 2-entry queue takes short bursts, then the input waits. A
// start command whose step does not saturate holds off input while the divider runs.
// Reset clears the fade state to alpha 0, idle, and loads configuration defaults.
// ============================================================================
// fade_wipe_controller
// Screen fade and wipe transition controller producing draw descriptors.
// ============================================================================
`default_nettype none

module fade_wipe_controller
    import fwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Command stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // duration_ms[15:0], alpha_value[23:16]
    input  logic [1:0]            s_tuser,   // op[1:0]
    // Descriptor stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // alpha_now, fade_phase, dest_x, dest_y,
                                             // dest_w, dest_h, src_x, src_y, src_w, src_h
    output logic [1:0]            m_tuser,   // draw_kind[1:0]
    output logic                  m_tlast
);

    cfg_t cfg;
    logic push;
    job_t push_job;
    logic q_full;
    logic q_empty;
    logic q_pop;
    job_t q_data;

    // Configuration registers.
    fwc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Command handling and classification.
    fwc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_user  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // Queue between the two parts.
    fwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // Descriptor generation.
    fwc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== dv/fade_wipe_controller_tb.sv =====
// ============================================================================
// fade_wipe_controller_tb
// Self-checking bench for the fade and wipe transition controller. Commands
// are pushed into the command stream from a queue, and an in-bench model of
// the fade state predicts every draw descriptor. Each descriptor transfer is
// compared field by field. The register set is changed between phases of
// random traffic, and both stream sides are throttled at random.
// ============================================================================

module fade_wipe_controller_tb;
    import fwc_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_PHASES = 18;
    localparam int PHASE_ITEMS   = 94;
    localparam int HOLD_PHASE    = 5;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;

    // One command as it travels on the command stream.
    typedef struct packed {
        op_t         op;
        logic [15:0] duration;
        logic [7:0]  alpha;
    } cmd_t;

    // One draw descriptor as the model predicts it.
    typedef struct packed {
        logic [7:0]         alpha;
        phase_t             phase;
        kind_t              kind;
        logic signed [12:0] dest_x;
        logic signed [12:0] dest_y;
        logic [11:0]        dest_w;
        logic [11:0]        dest_h;
        logic [11:0]        src_x;
        logic [11:0]        src_y;
        logic [11:0]        src_w;
        logic [11:0]        src_h;
        logic               last;
    } draw_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // duration_ms[15:0], alpha_value[23:16]
    logic [1:0]            s_tuser   = '0;   // op[1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // alpha_now, fade_phase, dest_x, dest_y,
                                             // dest_w, dest_h, src_x, src_y, src_w, src_h
    logic [1:0]            m_tuser;          // draw_kind[1:0]
    logic                  m_tlast;

    // Model copy of the registers and of the fade state.
    cfg_t       shadow_cfg = CFG_RESET;
    logic [7:0] alpha_lvl  = ALPHA_MIN;
    logic [7:0] step_amt   = '0;
    phase_t     fade_st    = PH_IDLE;
    logic       arm_in     = 1'b0;
    logic       arm_out    = 1'b0;

    cmd_t  cmds_waiting[$];
    draw_t draws_due[$];
    cmd_t  on_bus;
    desc_t seen;
    draw_t want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int run_phase      = 0;
    int hold_left      = 0;
    bit hold_used      = 1'b0;
    int quiet_cycles   = 0;
    int fail_count     = 0;
    int cmds_taken     = 0;
    int draws_seen     = 0;

    fade_wipe_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Screen positions saturate to the 13-bit signed range.
    function automatic logic signed [12:0] clip_pos(input int v);
        if (v > 4095)
            v = 4095;
        if (v < -4096)
            v = -4096;
        return 13'(v);
    endfunction

    // Builds a descriptor at the current alpha and phase.
    function automatic draw_t make_draw(input kind_t kind, input int dx, input int dy,
                                        input int dw, input int dh, input int sx,
                                        input int sy, input int sw, input int sh,
                                        input logic last);
        draw_t d;
        d.alpha  = alpha_lvl;
        d.phase  = fade_st;
        d.kind   = kind;
        d.dest_x = clip_pos(dx);
        d.dest_y = clip_pos(dy);
        d.dest_w = 12'(dw);
        d.dest_h = 12'(dh);
        d.src_x  = 12'(sx);
        d.src_y  = 12'(sy);
        d.src_w  = 12'(sw);
        d.src_h  = 12'(sh);
        d.last   = last;
        return d;
    endfunction

    // Partial rectangle: the covered size along the wipe axis is size*a/255.
    function automatic draw_t wipe_rect(input dir_t dir, input int a, input logic last);
        int    tx, ty, tw, th, sw, sh, dwp, dhp, swp, shp;
        draw_t d;
        tx  = $signed(shadow_cfg.target_x);
        ty  = $signed(shadow_cfg.target_y);
        tw  = shadow_cfg.target_width;
        th  = shadow_cfg.target_height;
        sw  = shadow_cfg.source_width;
        sh  = shadow_cfg.source_height;
        dwp = tw * a / int'(FULL_SCALE);
        dhp = th * a / int'(FULL_SCALE);
        swp = sw * a / int'(FULL_SCALE);
        shp = sh * a / int'(FULL_SCALE);
        case (dir)
            DIR_LEFT:
                d = make_draw(KIND_PART, tx, ty, dwp, th, 0, 0, swp, sh, last);
            DIR_RIGHT:
                d = make_draw(KIND_PART, tx + tw - dwp, ty, dwp, th, sw - swp, 0, swp, sh,
                              last);
            DIR_TOP:
                d = make_draw(KIND_PART, tx, ty, tw, dhp, 0, 0, sw, shp, last);
            DIR_BOTTOM:
                d = make_draw(KIND_PART, tx, ty + th - dhp, tw, dhp, 0, sh - shp, sw, shp,
                              last);
            DIR_CENTER_H:
                d = make_draw(KIND_PART, tx + tw / 2 - dwp / 2, ty, dwp, th,
                              sw / 2 - swp / 2, 0, swp, sh, last);
            default:
                d = make_draw(KIND_PART, tx, ty + th / 2 - dhp / 2, tw, dhp,
                              0, sh / 2 - shp / 2, sw, shp, last);
        endcase
        return d;
    endfunction

    // Advances the fade state for one accepted command and queues the
    // descriptors that it must produce.
    function automatic void apply_command(input cmd_t c);
        int s;
        int lvl;
        int a;
        int tx, ty;
        case (c.op)
            OP_TICK:
            begin
                case (fade_st)
                    PH_IDLE:
                    begin
                        // A pending fade-in wins over a pending fade-out.
                        if (arm_in)
                        begin
                            fade_st = PH_IN;
                            arm_in  = 1'b0;
                        end
                        else if (arm_out)
                        begin
                            fade_st = PH_OUT;
                            arm_out = 1'b0;
                        end
                    end
                    PH_IN:
                    begin
                        lvl = int'(alpha_lvl) - int'(step_amt);
                        if (lvl < int'(ALPHA_MIN))
                            lvl = int'(ALPHA_MIN);
                        alpha_lvl = 8'(lvl);
                        if (alpha_lvl == ALPHA_MIN)
                            fade_st = PH_DONE;
                    end
                    PH_OUT:
                    begin
                        lvl = int'(alpha_lvl) + int'(step_amt);
                        if (lvl > int'(ALPHA_MAX))
                            lvl = int'(ALPHA_MAX);
                        alpha_lvl = 8'(lvl);
                        if (alpha_lvl == ALPHA_MAX)
                            fade_st = PH_DONE;
                    end
                    default:
                        ;
                endcase
            end
            OP_FADE_IN, OP_FADE_OUT:
            begin
                // A zero duration saturates the step; a zero quotient is lifted to
                // the minimum step.
                if (c.duration == '0)
                    s = int'(STEP_MAX);
                else
                    s = (int'(FULL_SCALE) * int'(shadow_cfg.frames_per_second))
                        / int'(c.duration);
                if (s < int'(STEP_MIN))
                    s = int'(STEP_MIN);
                if (s > int'(STEP_MAX))
                    s = int'(STEP_MAX);
                step_amt = 8'(s);
                fade_st  = PH_IDLE;
                if (c.op == OP_FADE_IN)
                begin
                    alpha_lvl = ALPHA_MAX;
                    arm_in    = 1'b1;
                end
                else
                begin
                    alpha_lvl = ALPHA_MIN;
                    arm_out   = 1'b1;
                end
            end
            default:
                alpha_lvl = c.alpha;
        endcase

        a  = alpha_lvl;
        tx = $signed(shadow_cfg.target_x);
        ty = $signed(shadow_cfg.target_y);
        if (alpha_lvl == ALPHA_MIN)
            draws_due.push_back(make_draw(KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        else if (alpha_lvl >= ALPHA_MAX)
            draws_due.push_back(make_draw(KIND_FULL, tx, ty, shadow_cfg.target_width,
                                          shadow_cfg.target_height, 0, 0,
                                          shadow_cfg.source_width,
                                          shadow_cfg.source_height, 1'b1));
        else
        begin
            // Uncovering from one edge leaves the overlay against the opposite one.
            case (shadow_cfg.wipe_mode)
                WIPE_BLEND:
                    draws_due.push_back(make_draw(KIND_BLEND, tx, ty,
                                                  shadow_cfg.target_width,
                                                  shadow_cfg.target_height, 0, 0,
                                                  shadow_cfg.source_width,
                                                  shadow_cfg.source_height, 1'b1));
                WIPE_FROM_LEFT:
                    draws_due.push_back(wipe_rect(DIR_RIGHT, a, 1'b1));
                WIPE_FROM_RIGHT:
                    draws_due.push_back(wipe_rect(DIR_LEFT, a, 1'b1));
                WIPE_FROM_TOP:
                    draws_due.push_back(wipe_rect(DIR_BOTTOM, a, 1'b1));
                WIPE_FROM_BOTTOM:
                    draws_due.push_back(wipe_rect(DIR_TOP, a, 1'b1));
                WIPE_FROM_SIDES:
                    draws_due.push_back(wipe_rect(DIR_CENTER_H, a, 1'b1));
                WIPE_CENTER_SIDES:
                begin
                    draws_due.push_back(wipe_rect(DIR_LEFT, a / 2, 1'b0));
                    draws_due.push_back(wipe_rect(DIR_RIGHT, a / 2, 1'b1));
                end
                WIPE_FROM_TOP_BOT:
                    draws_due.push_back(wipe_rect(DIR_CENTER_V, a, 1'b1));
                WIPE_CENTER_TOP_BOT:
                begin
                    draws_due.push_back(wipe_rect(DIR_TOP, a / 2, 1'b0));
                    draws_due.push_back(wipe_rect(DIR_BOTTOM, a / 2, 1'b1));
                end
                default:
                    draws_due.push_back(make_draw(KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
            endcase
        end
    endfunction

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    task automatic queue_cmd(input op_t op, input logic [15:0] duration,
                             input logic [7:0] alpha);
        cmd_t c;
        c.op       = op;
        c.duration = duration;
        c.alpha    = alpha;
        cmds_waiting.push_back(c);
    endtask

    // One register write; the model copy follows at once as the block is idle.
    task automatic write_reg(input cfg_idx_t idx, input logic [11:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_WIPE_MODE:     shadow_cfg.wipe_mode         = value[3:0];
            REG_FPS:           shadow_cfg.frames_per_second = value[7:0];
            REG_TARGET_X:      shadow_cfg.target_x          = value;
            REG_TARGET_Y:      shadow_cfg.target_y          = value;
            REG_TARGET_WIDTH:  shadow_cfg.target_width      = value;
            REG_TARGET_HEIGHT: shadow_cfg.target_height     = value;
            REG_SOURCE_WIDTH:  shadow_cfg.source_width      = value;
            default:           shadow_cfg.source_height     = value;
        endcase
    endtask

    function automatic logic [11:0] pick_coord(input int k);
        case (k % 5)
            0:       return 12'h800;
            1:       return 12'h7FF;
            2:       return 12'h000;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] pick_size(input int k);
        case (k % 6)
            0:       return 12'h000;
            1:       return 12'hFFF;
            2:       return 12'($urandom_range(16));
            default: return 12'($urandom);
        endcase
    endfunction

    // Register set for one random phase: every wipe code in turn, the frame
    // rate at zero and at its limits, and rectangles at their extremes.
    task automatic program_setting(input int p);
        logic [3:0] mode;
        logic [7:0] fps;
        if (p < 16)
            mode = 4'(p);
        else if (p == 16)
            mode = WIPE_CENTER_SIDES;
        else
            mode = WIPE_CENTER_TOP_BOT;
        case (p)
            1:       fps = 8'd0;
            2:       fps = 8'd255;
            3:       fps = 8'd1;
            default: fps = 8'($urandom_range(255, 1));
        endcase
        write_reg(REG_WIPE_MODE, {8'($urandom), mode});
        write_reg(REG_FPS, {4'($urandom), fps});
        write_reg(REG_TARGET_X, pick_coord(p));
        write_reg(REG_TARGET_Y, pick_coord(p + 2));
        write_reg(REG_TARGET_WIDTH, pick_size(p));
        write_reg(REG_TARGET_HEIGHT, pick_size(p + 1));
        write_reg(REG_SOURCE_WIDTH, pick_size(p + 2));
        write_reg(REG_SOURCE_HEIGHT, pick_size(p + 3));
    endtask

    // Mostly whole fades (a start command followed by frame ticks with an
    // occasional alpha load), plus stray loads and commands of any kind.
    task automatic queue_random_traffic(input int budget);
        int          count;
        int          roll;
        int          ticks;
        logic [15:0] dur;
        logic [7:0]  av;
        count = 0;
        while (count < budget)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                case ($urandom_range(19))
                    0, 1, 2:    dur = 16'd0;
                    3, 4, 5:    dur = 16'($urandom);
                    default:    dur = 16'($urandom_range(2000, 1));
                endcase
                queue_cmd($urandom_range(1) ? OP_FADE_IN : OP_FADE_OUT, dur, 8'($urandom));
                ticks = $urandom_range(30, 2);
                count += 1 + ticks;
                repeat (ticks)
                begin
                    if ($urandom_range(9) == 0)
                        queue_cmd(OP_LOAD, 16'($urandom), 8'($urandom));
                    else
                        queue_cmd(OP_TICK, 16'($urandom), 8'($urandom));
                end
            end
            else if (roll < 85)
            begin
                case ($urandom_range(3))
                    0:       av = ALPHA_MIN;
                    1:       av = ALPHA_MAX;
                    default: av = 8'($urandom);
                endcase
                queue_cmd(OP_LOAD, 16'($urandom), av);
                count++;
            end
            else
            begin
                queue_cmd(op_t'($urandom_range(3)), 16'($urandom), 8'($urandom));
                count++;
            end
        end
    endtask

    // Waits until every command has gone in and every descriptor has come out.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (cmds_waiting.size() != 0 || s_tvalid || draws_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Command side: holds an offer until its transfer, then picks the next
    // command or idles at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                apply_command(on_bus);
                cmds_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmds_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = cmds_waiting.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.alpha, on_bus.duration};
                    s_tuser  <= on_bus.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Descriptor side: checks each transfer against the oldest prediction and
    // throttles tready, with one long hold-off in the designated phase.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                draws_seen++;
                seen = m_tdata[$bits(desc_t)-1:0];
                if (draws_due.size() == 0)
                begin
                    $error("descriptor transfer with no command behind it");
                    fail_count++;
                end
                else
                begin
                    want = draws_due.pop_front();
                    check_field("alpha_now", want.alpha, seen.alpha_now);
                    check_field("fade_phase", want.phase, seen.fade_phase);
                    check_field("draw_kind", want.kind, m_tuser);
                    check_field("dest_x", $signed(want.dest_x), $signed(seen.dest_x));
                    check_field("dest_y", $signed(want.dest_y), $signed(seen.dest_y));
                    check_field("dest_w", want.dest_w, seen.dest_w);
                    check_field("dest_h", want.dest_h, seen.dest_h);
                    check_field("src_x", want.src_x, seen.src_x);
                    check_field("src_y", want.src_y, seen.src_y);
                    check_field("src_w", want.src_w, seen.src_w);
                    check_field("src_h", want.src_h, seen.src_h);
                    check_field("last_of_run", want.last, m_tlast);
                end
            end
            if (!hold_used && run_phase == HOLD_PHASE)
            begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without any transfer on either stream ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("No transfer for %0d cycles; %0d descriptors still due.",
                             QUIET_LIMIT, draws_due.size());
                    $display("fade_wipe_controller verification failed");
                    $finish;
                end
            end
        end
    end

    // Sequence of the run: reset, directed commands, then random phases.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset output, alpha loads at the limits, fades with a saturated
        // step and with a zero quotient, and ticks in the complete phase.
        queue_cmd(OP_TICK,     16'hFFFF, 8'hFF);
        queue_cmd(OP_LOAD,     16'hFFFF, ALPHA_MAX);
        queue_cmd(OP_LOAD,     16'h0000, 8'd128);
        queue_cmd(OP_LOAD,     16'h5555, 8'd1);
        queue_cmd(OP_LOAD,     16'hAAAA, 8'd254);
        queue_cmd(OP_LOAD,     16'h0000, ALPHA_MIN);
        queue_cmd(OP_FADE_IN,  16'd0,    8'hAA);
        queue_cmd(OP_TICK,     16'h0000, 8'h00);
        queue_cmd(OP_TICK,     16'h1234, 8'h55);
        queue_cmd(OP_TICK,     16'hFFFF, 8'hFF);
        queue_cmd(OP_FADE_OUT, 16'hFFFF, 8'h55);
        queue_cmd(OP_TICK,     16'h0000, 8'h00);
        queue_cmd(OP_TICK,     16'h8001, 8'h81);
        queue_cmd(OP_TICK,     16'h7FFE, 8'h7E);
        queue_cmd(OP_FADE_IN,  16'd1,    8'h00);
        queue_cmd(OP_TICK,     16'h0000, 8'h00);
        queue_cmd(OP_TICK,     16'h0000, 8'h00);
        queue_cmd(OP_FADE_IN,  16'd150,  8'hFF);
        queue_cmd(OP_TICK,     16'h0000, 8'h00);
        queue_cmd(OP_TICK,     16'h0000, 8'h00);
        queue_cmd(OP_TICK,     16'h0000, 8'h00);
        queue_cmd(OP_TICK,     16'h0000, 8'h00);
        queue_cmd(OP_FADE_OUT, 16'd300,  8'h0F);
        queue_cmd(OP_TICK,     16'h0000, 8'hF0);
        queue_cmd(OP_TICK,     16'h0000, 8'h00);
        wait_quiet();

        // Random phases; throttling cycles through none, sender only,
        // receiver only and both.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_setting(p);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            run_phase = p + 1;
            queue_random_traffic(PHASE_ITEMS);
            wait_quiet();
        end

        $display("Run covered %0d commands and %0d descriptors over %0d register settings,",
                 cmds_taken, draws_seen, RANDOM_PHASES + 1);
        $display("all sixteen wipe codes, frame rates 0, 1 and 255, and extreme rectangles.");
        if (fail_count == 0)
            $display("fade_wipe_controller verification clean");
        else
            $display("fade_wipe_controller verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fwc_pkg.sv
sv/fwc_cfg.sv
sv/fwc_front.sv
sv/fwc_queue.sv
sv/fwc_back.sv
sv/fade_wipe_controller.sv
dv/fade_wipe_controller_tb.sv
